// ===== src/point_in_cylinder_test_macros.svh =====
// Assertion macros of the point-in-cylinder test RTL.
`ifndef POINT_IN_CYLINDER_TEST_MACROS_SVH
`define POINT_IN_CYLINDER_TEST_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define PIC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("point_in_cylinder_test: assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("point_in_cylinder_test: assertion failed");

`else

`define PIC_ASSERT(lbl, clk, rst_n, prop)
`define PIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/pic_pkg.sv =====
// Shared types, constants and width helpers of the point-in-cylinder test.
package pic_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 4;

	localparam int AXIS_W      = 16;
	localparam int AXIS_DIFF_W = AXIS_W + 1;
	localparam int RADIUS_W    = 15;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_START_X = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_START_Y = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_START_Z = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_END_X   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_END_Y   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] CFG_END_Z   = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS  = CFG_IDX_W'(6);

	localparam int STAGES = 8;

	typedef logic signed [AXIS_W-1:0] axis_t;
	typedef logic [RADIUS_W-1:0]      radius_t;
	typedef logic [STAGES-1:0]        stage_en_t;

	// Width of w = (point << frac) - start, signed.
	function automatic int diff_w(int coord_bits, int frac_bits);
		int pw;
		pw = coord_bits + frac_bits;
		return ((pw + 1 > AXIS_DIFF_W) ? pw + 1 : AXIS_DIFF_W) + 1;
	endfunction

	// Width of one signed product w_i * v_j.
	function automatic int prod_w(int coord_bits, int frac_bits);
		return diff_w(coord_bits, frac_bits) + AXIS_DIFF_W;
	endfunction

endpackage

// ===== src/pic_front.sv =====
// Stages one to three: offsets, all dot and cross products, and their sums.
module pic_front #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 4,
	localparam int WW  = pic_pkg::diff_w(COORD_BITS, FRAC_BITS),
	localparam int VW  = pic_pkg::AXIS_DIFF_W,
	localparam int PRW = WW + VW,
	localparam int DW  = PRW + 2,
	localparam int VVW = 2 * VW + 2,
	localparam int CW  = PRW + 1
) (
	input  logic                     clk,
	input  pic_pkg::stage_en_t       en,
	input  logic [COORD_BITS-1:0]    point_x,
	input  logic [COORD_BITS-1:0]    point_y,
	input  logic [COORD_BITS-1:0]    point_z,
	input  pic_pkg::axis_t           axis_start [3],
	input  pic_pkg::axis_t           axis_end [3],
	output logic signed [DW-1:0]     wv_s3,
	output logic signed [VVW-1:0]    vv_s3,
	output logic signed [CW-1:0]     cross_s3 [3]
);
	import pic_pkg::*;

	localparam int VPW = 2 * VW;

	logic [COORD_BITS-1:0]   pt [3];
	logic signed [WW-1:0]    w_s1 [3];
	logic signed [VW-1:0]    v_s1 [3];
	logic signed [PRW-1:0]   wv_s2 [3];
	logic signed [VPW-1:0]   vv_s2 [3];
	logic signed [PRW-1:0]   cp_s2 [6];

	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	// Stage 1: point scaled to the axis format, offsets from the start point.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				w_s1[i] <= (WW'(pt[i]) << FRAC_BITS) - WW'(axis_start[i]);
				v_s1[i] <= VW'(axis_end[i]) - VW'(axis_start[i]);
			end
		end
	end

	// Stage 2: every product that the dot and cross products need.
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				wv_s2[i] <= PRW'(w_s1[i]) * PRW'(v_s1[i]);
				vv_s2[i] <= VPW'(v_s1[i]) * VPW'(v_s1[i]);
			end
			cp_s2[0] <= PRW'(w_s1[1]) * PRW'(v_s1[2]);
			cp_s2[1] <= PRW'(w_s1[2]) * PRW'(v_s1[1]);
			cp_s2[2] <= PRW'(w_s1[2]) * PRW'(v_s1[0]);
			cp_s2[3] <= PRW'(w_s1[0]) * PRW'(v_s1[2]);
			cp_s2[4] <= PRW'(w_s1[0]) * PRW'(v_s1[1]);
			cp_s2[5] <= PRW'(w_s1[1]) * PRW'(v_s1[0]);
		end
	end

	// Stage 3: the two dot products and the three cross product components.
	always_ff @(posedge clk) begin
		if (en[2]) begin
			wv_s3 <= DW'(wv_s2[0]) + DW'(wv_s2[1]) + DW'(wv_s2[2]);
			vv_s3 <= VVW'(vv_s2[0]) + VVW'(vv_s2[1]) + VVW'(vv_s2[2]);
			for (int i = 0; i < 3; i++) begin
				cross_s3[i] <= CW'(cp_s2[2*i]) - CW'(cp_s2[2*i+1]);
			end
		end
	end

endmodule

// ===== src/pic_square.sv =====
// Stages four to six: segment test, squared cross magnitudes and radius limit.
module pic_square #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 4,
	localparam int PRW  = pic_pkg::prod_w(COORD_BITS, FRAC_BITS),
	localparam int VW   = pic_pkg::AXIS_DIFF_W,
	localparam int DW   = PRW + 2,
	localparam int VVW  = 2 * VW + 2,
	localparam int CW   = PRW + 1,
	localparam int SQW  = 2 * CW,
	localparam int VVU  = 2 * VW + 1,
	localparam int LIMW = 2 * pic_pkg::RADIUS_W + VVU
) (
	input  logic                     clk,
	input  pic_pkg::stage_en_t       en,
	input  pic_pkg::radius_t         cyl_radius,
	input  logic signed [DW-1:0]     wv_s3,
	input  logic signed [VVW-1:0]    vv_s3,
	input  logic signed [CW-1:0]     cross_s3 [3],
	output logic                     onseg_s6,
	output logic [SQW-1:0]           sq_s6 [3],
	output logic [LIMW-1:0]          lim_s6
);
	import pic_pkg::*;

	localparam int CM   = CW;
	localparam int H    = (CM + 1) / 2;
	localparam int HL   = CM - H;
	localparam int HHW  = 2 * HL;
	localparam int HLW  = HL + H;
	localparam int LLW  = 2 * H;
	localparam int RRW  = 2 * RADIUS_W;
	localparam int VH   = (VVU + 1) / 2;
	localparam int VHI  = VVU - VH;
	localparam int PHW  = RRW + VHI;
	localparam int PLW  = RRW + VH;
	localparam int CMPW = (DW > VVW) ? DW : VVW;

	logic            onseg_s4;
	logic [CM-1:0]   mag_s4 [3];
	logic [RRW-1:0]  rr_s4;
	logic [VVU-1:0]  vv_s4;

	logic            onseg_s5;
	logic [HHW-1:0]  hh_s5 [3];
	logic [HLW-1:0]  hl_s5 [3];
	logic [LLW-1:0]  ll_s5 [3];
	logic [PHW-1:0]  lh_s5;
	logic [PLW-1:0]  lo_s5;

	logic signed [CMPW-1:0] wv_x;
	logic signed [CMPW-1:0] vv_x;

	assign wv_x = CMPW'(wv_s3);
	assign vv_x = CMPW'(vv_s3);

	// Stage 4: projection range check, magnitudes, radius squared.
	always_ff @(posedge clk) begin
		if (en[3]) begin
			onseg_s4 <= (vv_s3 != '0) && !wv_s3[DW-1] && (wv_x <= vv_x);
			for (int i = 0; i < 3; i++) begin
				mag_s4[i] <= cross_s3[i][CW-1] ? CM'(-cross_s3[i]) : CM'(cross_s3[i]);
			end
			rr_s4 <= RRW'(cyl_radius) * RRW'(cyl_radius);
			vv_s4 <= vv_s3[VVU-1:0];
		end
	end

	// Stage 5: partial products of the squares and of the radius limit.
	always_ff @(posedge clk) begin
		if (en[4]) begin
			onseg_s5 <= onseg_s4;
			for (int i = 0; i < 3; i++) begin
				hh_s5[i] <= HHW'(mag_s4[i][CM-1:H]) * HHW'(mag_s4[i][CM-1:H]);
				hl_s5[i] <= HLW'(mag_s4[i][CM-1:H]) * HLW'(mag_s4[i][H-1:0]);
				ll_s5[i] <= LLW'(mag_s4[i][H-1:0]) * LLW'(mag_s4[i][H-1:0]);
			end
			lh_s5 <= PHW'(rr_s4) * PHW'(vv_s4[VVU-1:VH]);
			lo_s5 <= PLW'(rr_s4) * PLW'(vv_s4[VH-1:0]);
		end
	end

	// Stage 6: partial products recombined.
	always_ff @(posedge clk) begin
		if (en[5]) begin
			onseg_s6 <= onseg_s5;
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= (SQW'(hh_s5[i]) << (2 * H)) + (SQW'(hl_s5[i]) << (H + 1))
					+ SQW'(ll_s5[i]);
			end
			lim_s6 <= (LIMW'(lh_s5) << VH) + LIMW'(lo_s5);
		end
	end

endmodule

// ===== src/pic_compare.sv =====
// Stages seven and eight: squared distance sum and the final radius compare.
module pic_compare #(
	parameter int COORD_BITS = 12,
	parameter int FRAC_BITS  = 4,
	localparam int CW   = pic_pkg::prod_w(COORD_BITS, FRAC_BITS) + 1,
	localparam int SQW  = 2 * CW,
	localparam int LIMW = 2 * pic_pkg::RADIUS_W + 2 * pic_pkg::AXIS_DIFF_W + 1
) (
	input  logic                 clk,
	input  pic_pkg::stage_en_t   en,
	input  logic                 onseg_s6,
	input  logic [SQW-1:0]       sq_s6 [3],
	input  logic [LIMW-1:0]      lim_s6,
	output logic                 on_segment_s8,
	output logic                 inside_s8
);
	import pic_pkg::*;

	localparam int C2W  = SQW + 2;
	localparam int CMPW = (C2W > LIMW) ? C2W : LIMW;

	logic             onseg_s7;
	logic [C2W-1:0]   cross2_s7;
	logic [LIMW-1:0]  lim_s7;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			onseg_s7  <= onseg_s6;
			cross2_s7 <= C2W'(sq_s6[0]) + C2W'(sq_s6[1]) + C2W'(sq_s6[2]);
			lim_s7    <= lim_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			on_segment_s8 <= onseg_s7;
			inside_s8     <= onseg_s7 && (CMPW'(cross2_s7) < CMPW'(lim_s7));
		end
	end

endmodule

// ===== src/point_in_cylinder_test.sv =====
// Top level of the point-in-finite-cylinder test: config registers, pipeline control.

// Tests whole-voxel points against a finite cylinder whose axis runs from
// axis_start to axis_end, with radius cyl_radius, all in fixed point with
// FRAC_BITS fraction bits (signed endpoints, unsigned radius). Each point gives
// one item on the output: on_segment is set when the projection onto the axis
// lies between the endpoints (both endpoints included), and inside_res when the
// point is in addition strictly closer to the axis than the radius.
// A zero-length axis reports both flags clear. The arithmetic is exact integer
// math, with no division or square root. The datapath is an eight-stage pipeline
// that takes one item every clock cycle unless stalled; the depth is set by the
// chain of multiplications, the widest of which, the squared cross product
// magnitude, is split into half-width partial products over two stages. Each
// stage has its own valid bit and holds its item only while the stage after it
// is full and stalled, so empty slots are filled even while a finished result
// waits at the output. Configuration is taken through a separate write port that
// is always ready; registers may only be written while no item is in flight.
// Writes to index seven are ignored. Config and valid registers reset to zero.

`include "point_in_cylinder_test_macros.svh"

module point_in_cylinder_test #(
	parameter int COORD_BITS = pic_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = pic_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [COORD_BITS-1:0]             point_x,
	input  logic [COORD_BITS-1:0]             point_y,
	input  logic [COORD_BITS-1:0]             point_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              on_segment,
	output logic                              inside_res,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pic_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pic_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import pic_pkg::*;

	localparam int PRW  = prod_w(COORD_BITS, FRAC_BITS);
	localparam int DW   = PRW + 2;
	localparam int VVW  = 2 * AXIS_DIFF_W + 2;
	localparam int CW   = PRW + 1;
	localparam int SQW  = 2 * CW;
	localparam int LIMW = 2 * RADIUS_W + 2 * AXIS_DIFF_W + 1;

	// Cylinder description, written through the configuration port.
	axis_t   axis_start_q [3];
	axis_t   axis_end_q [3];
	radius_t cyl_radius_q;

	// One valid bit per pipeline stage and the load enables derived from them.
	logic [STAGES-1:0] vld_q;
	stage_en_t         stage_en;

	logic signed [DW-1:0]  wv_s3;
	logic signed [VVW-1:0] vv_s3;
	logic signed [CW-1:0]  cross_s3 [3];
	logic                  onseg_s6;
	logic [SQW-1:0]        sq_s6 [3];
	logic [LIMW-1:0]       lim_s6;
	logic                  on_segment_s8;
	logic                  inside_s8;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				axis_start_q[i] <= '0;
				axis_end_q[i]   <= '0;
			end
			cyl_radius_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_START_X: axis_start_q[0] <= cfg_data[AXIS_W-1:0];
				CFG_START_Y: axis_start_q[1] <= cfg_data[AXIS_W-1:0];
				CFG_START_Z: axis_start_q[2] <= cfg_data[AXIS_W-1:0];
				CFG_END_X:   axis_end_q[0]   <= cfg_data[AXIS_W-1:0];
				CFG_END_Y:   axis_end_q[1]   <= cfg_data[AXIS_W-1:0];
				CFG_END_Z:   axis_end_q[2]   <= cfg_data[AXIS_W-1:0];
				CFG_RADIUS:  cyl_radius_q    <= cfg_data[RADIUS_W-1:0];
				default: ;
			endcase
		end
	end

	// A stage may load when it is empty or when its item moves on this cycle.
	always_comb begin
		stage_en[STAGES-1] = !vld_q[STAGES-1] || out_ready;
		for (int k = STAGES - 2; k >= 0; k--) begin
			stage_en[k] = !vld_q[k] || stage_en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (stage_en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < STAGES; k++) begin
				if (stage_en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready   = stage_en[0];
	assign out_valid  = vld_q[STAGES-1];
	assign on_segment = on_segment_s8;
	assign inside_res = inside_s8;

	pic_front #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_front (
		.clk        (clk),
		.en         (stage_en),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.axis_start (axis_start_q),
		.axis_end   (axis_end_q),
		.wv_s3      (wv_s3),
		.vv_s3      (vv_s3),
		.cross_s3   (cross_s3)
	);

	pic_square #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_square (
		.clk        (clk),
		.en         (stage_en),
		.cyl_radius (cyl_radius_q),
		.wv_s3      (wv_s3),
		.vv_s3      (vv_s3),
		.cross_s3   (cross_s3),
		.onseg_s6   (onseg_s6),
		.sq_s6      (sq_s6),
		.lim_s6     (lim_s6)
	);

	pic_compare #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_compare (
		.clk           (clk),
		.en            (stage_en),
		.onseg_s6      (onseg_s6),
		.sq_s6         (sq_s6),
		.lim_s6        (lim_s6),
		.on_segment_s8 (on_segment_s8),
		.inside_s8     (inside_s8)
	);

	// A point inside the cylinder is always on the segment.
	`PIC_ASSERT(a_inside_needs_seg, clk, arst_n, !out_valid || on_segment || !inside_res)
	// An empty first stage is always ready for a new item.
	`PIC_ASSERT(a_bubble_filled, clk, arst_n, vld_q[0] || in_ready)
	// An item held by a stall in the middle of the pipe is not lost.
	`PIC_ASSERT_NEXT(a_stall_keeps, clk, arst_n, vld_q[1] && !stage_en[1], vld_q[1])
	// A result leaves the output only when it was taken.
	`PIC_ASSERT(a_out_leaves_taken, clk, arst_n, !$fell(out_valid) || $past(out_ready))

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the point-in-finite-cylinder test block.
`timescale 1ns / 100ps

module tb_top;
	import pic_pkg::*;

	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 4;
	localparam int COORD_W       = COORD_BITS_DEF;
	localparam int FRAC          = FRAC_BITS_DEF;
	localparam int COORD_MAX     = (1 << COORD_W) - 1;
	// The pipeline is eight stages deep; this wait adds margin on top of its depth.
	localparam int SETTLE_CYCLES = 12;
	// Longest legal quiet stretch is a sender gap plus the pipeline plus a receiver
	// stall; this limit leaves a wide margin.
	localparam int QUIET_LIMIT   = 2000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_ITEMS   = 113;

	// Index seven has no register behind it; writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(7);

	// The two flags that one point produces.
	typedef struct packed {
		logic on_segment;
		logic inside_flag;
	} cyl_flags_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [COORD_W-1:0]    point_x;
	logic [COORD_W-1:0]    point_y;
	logic [COORD_W-1:0]    point_z;
	logic                  out_valid;
	logic                  out_ready;
	logic                  on_segment;
	logic                  inside_res;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Our own copy of the cylinder registers, updated whenever a write is accepted.
	axis_t   axis_lo [3];
	axis_t   axis_hi [3];
	radius_t radius_q;

	// Flags of every accepted point whose result has not come out yet, oldest first.
	cyl_flags_t pending_flags [$];
	cyl_flags_t oldest_flags;
	int         mismatch_count;
	int         quiet_cycles;

	// Sender pacing: bursts of items separated by gaps, unless the phase is steady.
	int         burst_left;
	bit         steady;
	// Receiver pacing: out_ready follows this rotating pattern.
	logic [15:0] stall_pattern;

	point_in_cylinder_test u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.on_segment (on_segment),
		.inside_res (inside_res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Works out both flags for one voxel against the current cylinder. The point is
	// moved into the register format, then w = P - S and v = E - S give the
	// projection test 0 <= w.v <= v.v and the radius test |w x v|^2 < r^2 * v.v.
	// Everything stays exact: dot products fit in 64 bits, squares need 128.
	function automatic cyl_flags_t cylinder_flags(input logic [COORD_W-1:0] px,
			input logic [COORD_W-1:0] py, input logic [COORD_W-1:0] pz);
		longint             pt [3];
		longint             w [3];
		longint             v [3];
		longint             c [3];
		longint             dot_wv;
		longint             dot_vv;
		logic signed [127:0] c0, c1, c2, r2, vv_wide, cross_sq, limit;
		cyl_flags_t         f;
		pt[0] = longint'(px);
		pt[1] = longint'(py);
		pt[2] = longint'(pz);
		dot_wv = 0;
		dot_vv = 0;
		for (int i = 0; i < 3; i++) begin
			w[i] = (pt[i] <<< FRAC) - longint'(axis_lo[i]);
			v[i] = longint'(axis_hi[i]) - longint'(axis_lo[i]);
			dot_wv += w[i] * v[i];
			dot_vv += v[i] * v[i];
		end
		// A zero-length axis has no segment, so nothing can be on it.
		f.on_segment = (dot_vv != 0) && (dot_wv >= 0) && (dot_wv <= dot_vv);
		f.inside_flag = 1'b0;
		if (f.on_segment) begin
			c[0] = w[1] * v[2] - w[2] * v[1];
			c[1] = w[2] * v[0] - w[0] * v[2];
			c[2] = w[0] * v[1] - w[1] * v[0];
			c0 = 128'(c[0]);
			c1 = 128'(c[1]);
			c2 = 128'(c[2]);
			cross_sq = c0 * c0 + c1 * c1 + c2 * c2;
			r2 = 128'(radius_q);
			vv_wide = 128'(dot_vv);
			limit = r2 * r2 * vv_wide;
			// Strict compare: a point exactly on the surface is outside.
			f.inside_flag = cross_sq < limit;
		end
		return f;
	endfunction

	// Picks a voxel coordinate near the line through s and e: t32 is the position
	// along the axis in 1/32 steps, span the spread around it in register units.
	function automatic int near_voxel(input axis_t s, input axis_t e,
			input int t32, input int span);
		longint f;
		int     off;
		off = int'($urandom_range(0, 2 * span)) - span;
		f = longint'(s) + ((longint'(e) - longint'(s)) * t32) / 32 + off;
		f = f >>> FRAC;
		if (f < 0)
			f = 0;
		else if (f > COORD_MAX)
			f = COORD_MAX;
		return int'(f);
	endfunction

	// One of the corner values of a signed register word, or a random one.
	function automatic logic [15:0] extreme_word();
		case ($urandom_range(0, 3))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			default: return 16'($urandom());
		endcase
	endfunction

	// Offers one point and waits for the block to take it. The valid line stays
	// high into the next call unless the current burst has run out, in which case
	// the sender drops it for a random gap.
	task automatic send_voxel(input int x, input int y, input int z);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		point_x  <= COORD_W'(x);
		point_y  <= COORD_W'(y);
		point_z  <= COORD_W'(z);
		do @(posedge clk); while (!in_ready);
		pending_flags.insert(pending_flags.size(),
			cylinder_flags(COORD_W'(x), COORD_W'(y), COORD_W'(z)));
		if (!steady) begin
			burst_left--;
			if (burst_left <= 0) begin
				gap = $urandom_range(1, 8);
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
				burst_left = $urandom_range(1, 24);
			end
		end
	endtask

	// Writes one register and mirrors the write in our copy. Unknown indexes and
	// bits above a register's width are dropped, just as the block drops them.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_START_X: axis_lo[0] = data;
			CFG_START_Y: axis_lo[1] = data;
			CFG_START_Z: axis_lo[2] = data;
			CFG_END_X:   axis_hi[0] = data;
			CFG_END_Y:   axis_hi[1] = data;
			CFG_END_Z:   axis_hi[2] = data;
			CFG_RADIUS:  radius_q   = data[RADIUS_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_cylinder(input logic [15:0] sx, input logic [15:0] sy,
			input logic [15:0] sz, input logic [15:0] ex, input logic [15:0] ey,
			input logic [15:0] ez, input logic [15:0] r);
		write_reg(CFG_START_X, sx);
		write_reg(CFG_START_Y, sy);
		write_reg(CFG_START_Z, sz);
		write_reg(CFG_END_X, ex);
		write_reg(CFG_END_Y, ey);
		write_reg(CFG_END_Z, ez);
		write_reg(CFG_RADIUS, r);
	endtask

	// Stops offering points and waits until the pipeline is empty, so that the
	// registers can be rewritten safely. Ends on a rising edge.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_flags.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Right after reset every register is zero, so the axis has no length and
	// every point is off the segment. Then a nonzero but degenerate axis.
	task automatic test_zero_axis();
		stall_pattern = 16'hFFFF;
		steady = 1'b1;
		send_voxel(0, 0, 0);
		send_voxel(COORD_MAX, COORD_MAX, COORD_MAX);
		send_voxel(0, COORD_MAX, 0);
		settle();
		load_cylinder(16'd1600, 16'd1600, 16'd1600, 16'd1600, 16'd1600, 16'd1600, 16'd800);
		send_voxel(100, 100, 100);
	endtask

	// An axis along x from voxel 10 to voxel 20 with a radius of three voxels.
	// Covers projections exactly at both endpoints, just past them, points on
	// the surface and points strictly inside.
	task automatic test_endpoints_and_surface();
		settle();
		stall_pattern = 16'($urandom()) | 16'h8001;
		steady = 1'b0;
		load_cylinder(16'd160, 16'd160, 16'd160, 16'd320, 16'd160, 16'd160, 16'd48);
		send_voxel(10, 10, 10);
		send_voxel(20, 10, 10);
		send_voxel(9, 10, 10);
		send_voxel(21, 10, 10);
		send_voxel(15, 13, 10);
		send_voxel(15, 12, 10);
		send_voxel(15, 10, 7);
		send_voxel(15, 10, 14);
		send_voxel(12, 11, 11);
	endtask

	// Endpoints at the most negative and most positive register values, and a
	// radius word with its top bit set, which must be cut down to 15 bits. Then
	// a radius whose only set bit lies above the register, so that it reads as zero,
	// and a write to the unused index, which may change nothing.
	task automatic test_extreme_registers();
		settle();
		stall_pattern = 16'h0101;
		load_cylinder(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
		send_voxel(0, 0, 0);
		send_voxel(COORD_MAX, COORD_MAX, COORD_MAX);
		send_voxel(COORD_MAX, 0, 0);
		send_voxel(0, COORD_MAX, 0);
		send_voxel(0, 0, COORD_MAX);
		send_voxel(2048, 2048, 2048);
		send_voxel(2047, 0, COORD_MAX);
		settle();
		write_reg(CFG_RADIUS, 16'h8000);
		write_reg(CFG_UNUSED, 16'hFFFF);
		send_voxel(2048, 2048, 2048);
		send_voxel(1000, 1000, 1000);
	endtask

	// Phases of random cylinders. Most points are drawn close to the axis, a bit
	// before its start to a bit past its end, so that both flags change often;
	// the rest are uniform noise over the whole voxel range.
	task automatic test_random_cylinders();
		logic [15:0] sv [3];
		logic [15:0] ev [3];
		logic [15:0] rv;
		int          t32;
		int          span;
		int          a;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			case ($urandom_range(0, 3))
				0: stall_pattern = 16'hFFFF;
				1: stall_pattern = 16'h0001;
				2: stall_pattern = 16'h7FFF;
				default: stall_pattern = 16'($urandom()) | 16'h0001;
			endcase
			steady = (phase % 3 == 0);
			case (phase % 4)
				0: begin
					// Any register word at all.
					for (int i = 0; i < 3; i++) begin
						sv[i] = 16'($urandom());
						ev[i] = 16'($urandom());
					end
					rv = 16'($urandom());
				end
				1: begin
					// A cylinder inside the reachable voxel range.
					for (int i = 0; i < 3; i++) begin
						sv[i] = 16'($urandom_range(0, 32767));
						ev[i] = 16'($urandom_range(0, 32767));
					end
					rv = 16'($urandom_range(0, 4095));
				end
				2: begin
					// A short axis along one direction, sometimes of zero length.
					a = $urandom_range(0, 2);
					for (int i = 0; i < 3; i++) begin
						sv[i] = 16'($urandom_range(0, 30000));
						ev[i] = sv[i];
					end
					ev[a] = sv[a] + 16'($urandom_range(0, 64));
					rv = 16'($urandom_range(0, 200));
				end
				default: begin
					// Corner values for every register.
					for (int i = 0; i < 3; i++) begin
						sv[i] = extreme_word();
						ev[i] = extreme_word();
					end
					case ($urandom_range(0, 3))
						0: rv = 16'h0000;
						1: rv = 16'h7FFF;
						2: rv = 16'h0001;
						default: rv = 16'hFFFF;
					endcase
				end
			endcase
			load_cylinder(sv[0], sv[1], sv[2], ev[0], ev[1], ev[2], rv);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 3) == 0) begin
					send_voxel(int'($urandom_range(0, COORD_MAX)),
						int'($urandom_range(0, COORD_MAX)),
						int'($urandom_range(0, COORD_MAX)));
				end else begin
					t32 = int'($urandom_range(0, 48)) - 8;
					span = int'(radius_q) + 32;
					send_voxel(near_voxel(axis_lo[0], axis_hi[0], t32, span),
						near_voxel(axis_lo[1], axis_hi[1], t32, span),
						near_voxel(axis_lo[2], axis_hi[2], t32, span));
				end
			end
		end
	endtask

	// The receiver rotates its pattern every cycle; a zero bit is a stall.
	always @(negedge clk) begin
		out_ready     <= stall_pattern[0];
		stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
	end

	// Every result taken by the receiver is matched against the oldest pending point.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_flags.size() == 0) begin
				$error("result with no point pending: on_segment=%0b inside_res=%0b",
					on_segment, inside_res);
				mismatch_count++;
			end else begin
				oldest_flags = pending_flags.pop_front();
				if (on_segment !== oldest_flags.on_segment) begin
					$error("on_segment: expected %0b, got %0b",
						oldest_flags.on_segment, on_segment);
					mismatch_count++;
				end
				if (inside_res !== oldest_flags.inside_flag) begin
					$error("inside_res: expected %0b, got %0b",
						oldest_flags.inside_flag, inside_res);
					mismatch_count++;
				end
			end
		end
	end

	// Ends a hung run: any accepted item on any channel restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		point_x        = '0;
		point_y        = '0;
		point_z        = '0;
		out_ready      = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = CFG_START_X;
		cfg_data       = '0;
		stall_pattern  = 16'hFFFF;
		steady         = 1'b1;
		burst_left     = 8;
		mismatch_count = 0;
		quiet_cycles   = 0;
		for (int i = 0; i < 3; i++) begin
			axis_lo[i] = '0;
			axis_hi[i] = '0;
		end
		radius_q = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_zero_axis();
		test_endpoints_and_surface();
		test_extreme_registers();
		test_random_cylinders();

		// Drain the pipeline; a result that never arrives trips the watchdog.
		settle();
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== point_in_cylinder_test.f =====
+incdir+src
src/pic_pkg.sv
src/pic_front.sv
src/pic_square.sv
src/pic_compare.sv
src/point_in_cylinder_test.sv
bench/tb_top.sv
